/* design/peda_pkg.sv */
// ----------------------------------------------------------------------------
// peda_pkg
// Types and constants shared by the pad edge and autorepeat block.
// ----------------------------------------------------------------------------
package peda_pkg;

   // Buttons plus two directions for each of the four stick axes
   localparam int NUM_LANES   = 20;
   localparam int NUM_OUTPUTS = 22;

   localparam int CENTER_WIDTH    = 8;
   localparam int THRESHOLD_WIDTH = 7;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANALOG_CENTER    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANALOG_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENTER_IS_CIRCLE  = 2'd2;

   localparam logic [CENTER_WIDTH-1:0]    CENTER_RESET    = 8'd128;
   localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET = 7'd64;

   typedef struct packed {
      logic [11:0] button_bits;
      logic [7:0]  left_x;
      logic [7:0]  left_y;
      logic [7:0]  right_x;
      logic [7:0]  right_y;
   } req_type;

   typedef struct packed {
      logic [NUM_OUTPUTS-1:0] held_mask;
      logic [NUM_OUTPUTS-1:0] pressed_mask;
      logic [NUM_OUTPUTS-1:0] released_mask;
      logic [NUM_OUTPUTS-1:0] slow_repeat_mask;
      logic [NUM_OUTPUTS-1:0] fast_repeat_mask;
   } rsp_type;

   // Per-lane flags for one poll, before enter and cancel are added
   typedef struct packed {
      logic [NUM_LANES-1:0] held;
      logic [NUM_LANES-1:0] pressed;
      logic [NUM_LANES-1:0] released;
      logic [NUM_LANES-1:0] slow;
      logic [NUM_LANES-1:0] fast;
   } lane_status_type;

endpackage

/* design/peda_lane_decode.sv */
// ----------------------------------------------------------------------------
// peda_lane_decode
// Turns one poll into lane bits: the buttons, then low and high directions
// for left y, left x, right y and right x.
// ----------------------------------------------------------------------------
module peda_lane_decode
   import peda_pkg::*;
(
   input  req_type                     poll,
   input  logic [CENTER_WIDTH-1:0]     center,
   input  logic [THRESHOLD_WIDTH-1:0]  threshold,
   output logic [NUM_LANES-1:0]        lanes
);

   // Bit 0 low, bit 1 high; low wins, and a window past the range never fires
   function automatic logic [1:0] axis_dir(input logic [7:0] pos,
                                           input logic [CENTER_WIDTH-1:0] ctr,
                                           input logic [THRESHOLD_WIDTH-1:0] thr);
      logic [8:0] pos_plus;
      logic [8:0] ctr_plus;
      logic [1:0] dir;
      pos_plus = {1'b0, pos} + {2'b00, thr};
      ctr_plus = {1'b0, ctr} + {2'b00, thr};
      if (pos_plus < {1'b0, ctr}) begin
         dir = 2'b01;
      end else if ({1'b0, pos} > ctr_plus) begin
         dir = 2'b10;
      end else begin
         dir = 2'b00;
      end
      return dir;
   endfunction

   assign lanes = {axis_dir(poll.right_x, center, threshold),
                   axis_dir(poll.right_y, center, threshold),
                   axis_dir(poll.left_x,  center, threshold),
                   axis_dir(poll.left_y,  center, threshold),
                   poll.button_bits};

endmodule

/* design/peda_repeat.sv */
// ----------------------------------------------------------------------------
// peda_repeat
// Per-lane edge detection and the two autorepeat counters. State moves on
// only when the caller advances a poll into the result register.
// ----------------------------------------------------------------------------
module peda_repeat
   import peda_pkg::*;
#(
   parameter int LANE_COUNT = 20
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [NUM_LANES-1:0]  lanes,
   output lane_status_type       status
);

   localparam logic [3:0] REPEAT_DELAY = 4'd10;
   localparam logic [3:0] SLOW_RELOAD  = 4'd6;

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      if (i < LANE_COUNT) begin : g_live
         logic       prev_ff;
         logic       prev_in;
         logic [3:0] slow_ff;
         logic [3:0] slow_in;
         logic [3:0] fast_ff;
         logic [3:0] fast_in;
         logic       slow_fire;
         logic       fast_fire;
         logic [3:0] slow_base;
         logic [3:0] fast_base;

         always_comb begin
            slow_fire = lanes[i] && (slow_ff >= REPEAT_DELAY);
            fast_fire = lanes[i] && (fast_ff >= REPEAT_DELAY);
            slow_base = slow_fire ? SLOW_RELOAD : slow_ff;
            fast_base = fast_fire ? REPEAT_DELAY : fast_ff;
            prev_in   = lanes[i];
            slow_in   = lanes[i] ? slow_base + 4'd1 : 4'd0;
            fast_in   = lanes[i] ? fast_base + 4'd1 : 4'd0;
         end

         assign status.held[i]     = lanes[i];
         assign status.pressed[i]  = lanes[i] && !prev_ff;
         assign status.released[i] = !lanes[i] && prev_ff;
         assign status.slow[i]     = (lanes[i] && !prev_ff) || slow_fire;
         assign status.fast[i]     = (lanes[i] && !prev_ff) || fast_fire;

         always_ff @(posedge clock) begin
            if (reset) begin
               prev_ff <= 1'b0;
               slow_ff <= 4'd0;
               fast_ff <= 4'd0;
            end else if (advance) begin
               prev_ff <= prev_in;
               slow_ff <= slow_in;
               fast_ff <= fast_in;
            end
         end
      end else begin : g_dead
         // Lane not built: never active
         assign status.held[i]     = 1'b0;
         assign status.pressed[i]  = 1'b0;
         assign status.released[i] = 1'b0;
         assign status.slow[i]     = 1'b0;
         assign status.fast[i]     = 1'b0;
      end
   end

endmodule

/* design/pad_edge_and_autorepeat.sv */
// ----------------------------------------------------------------------------
// pad_edge_and_autorepeat
// Button and stick edge detector with slow and fast autorepeat per lane.
//
//   channel   ports                               direction
//   req       req_valid, req_stall, req_data      poll in
//   rsp       rsp_valid, rsp_stall, rsp_data      lane masks out
//   csr       csr_write, csr_index, csr_wdata     register writes
//
// A poll is held in the input register, then is decoded and loaded into
// the result register, which drives rsp_valid; one poll per cycle is
// sustained while the result is not stalled. Lane history and repeat
// counters move when a poll enters the result register. Reset clears
// history, counters and both valid flags and loads the register defaults.
// A stalled result holds the input register; req_stall rises only when
// both registers are full.
// ----------------------------------------------------------------------------
module pad_edge_and_autorepeat
   import peda_pkg::*;
#(
   parameter int LANE_COUNT = 20
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  req_type                     req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rsp_type                     rsp_data,
   input  logic                        csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int LANE_CIRCLE = 7;
   localparam int LANE_CROSS  = 8;

   logic [CENTER_WIDTH-1:0]    center_ff;
   logic [THRESHOLD_WIDTH-1:0] threshold_ff;
   logic                       enter_is_circle_ff;

   req_type         req_ff;
   logic            req_valid_ff;
   logic            req_valid_in;
   rsp_type         rsp_ff;
   rsp_type         rsp_in;
   logic            rsp_valid_ff;
   logic            advance;
   logic            req_take;
   logic [NUM_LANES-1:0] lanes;
   lane_status_type status;

   // Add enter and cancel, copied from circle or cross
   function automatic logic [NUM_OUTPUTS-1:0] mirror(input logic [NUM_LANES-1:0] word,
                                                     input logic circle_enter);
      logic ent;
      logic can;
      ent = circle_enter ? word[LANE_CIRCLE] : word[LANE_CROSS];
      can = circle_enter ? word[LANE_CROSS]  : word[LANE_CIRCLE];
      return {can, ent, word};
   endfunction

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
   end

   peda_lane_decode u_decode (
      .poll      (req_ff),
      .center    (center_ff),
      .threshold (threshold_ff),
      .lanes     (lanes)
   );

   peda_repeat #(
      .LANE_COUNT (LANE_COUNT)
   ) u_repeat (
      .clock   (clock),
      .reset   (reset),
      .advance (advance && req_valid_ff),
      .lanes   (lanes),
      .status  (status)
   );

   always_comb begin
      rsp_in.held_mask        = mirror(status.held,     enter_is_circle_ff);
      rsp_in.pressed_mask     = mirror(status.pressed,  enter_is_circle_ff);
      rsp_in.released_mask    = mirror(status.released, enter_is_circle_ff);
      rsp_in.slow_repeat_mask = mirror(status.slow,     enter_is_circle_ff);
      rsp_in.fast_repeat_mask = mirror(status.fast,     enter_is_circle_ff);
   end

   // Registers; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff          <= CENTER_RESET;
         threshold_ff       <= THRESHOLD_RESET;
         enter_is_circle_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ANALOG_CENTER: begin
               center_ff <= csr_wdata[CENTER_WIDTH-1:0];
            end
            CSR_ANALOG_THRESHOLD: begin
               threshold_ff <= csr_wdata[THRESHOLD_WIDTH-1:0];
            end
            CSR_ENTER_IS_CIRCLE: begin
               enter_is_circle_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (advance && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
